>>> hdl/izn_pkg.sv
// Shared types, constants and helpers for the Izhikevich neuron step block.
package izn_pkg;

	localparam int VAL_W     = 32;
	localparam int UVAL_W    = 31;
	localparam int CFG_IDX_W = 4;
	localparam int FRAC_W    = 16;
	localparam int SUM_W     = 52;
	localparam int PROD_W    = 66;
	localparam int SQ_W      = 44;

	localparam logic [11:0] COEF_SQUARE = 12'd2621;
	localparam logic signed [SUM_W-1:0] CONST_BIAS = 52'sd140 <<< FRAC_W;
	localparam logic signed [SUM_W-1:0] SAT_HI = 52'sd2147483647;
	localparam logic signed [SUM_W-1:0] SAT_LO = -52'sd2147483648;

	localparam logic signed [VAL_W-1:0] POTENTIAL_RESET = -32'sd4259840;
	localparam logic signed [VAL_W-1:0] RECOVERY_RESET  = -32'sd851968;

	localparam logic signed [VAL_W-1:0] RATE_RESET      = 32'sd1311;
	localparam logic signed [VAL_W-1:0] SENS_RESET      = 32'sd13107;
	localparam logic signed [VAL_W-1:0] RESET_POT_RESET = -32'sd4259840;
	localparam logic signed [VAL_W-1:0] JUMP_RESET      = 32'sd524288;
	localparam logic signed [VAL_W-1:0] THRESH_RESET    = 32'sd1966080;
	localparam logic signed [VAL_W-1:0] WEIGHT_RESET    = 32'sd65536;
	localparam logic [UVAL_W-1:0]       STEP_RESET      = 31'd64000;
	localparam logic [UVAL_W-1:0]       AMP_RESET       = 31'd671088640;

	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE        = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SENSITIVITY = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_JUMP        = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD       = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_WEIGHT         = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_MS              = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_AMPLITUDE      = 4'd7;

	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_VV     = 4'd1;
	localparam logic [3:0] OP_CUR    = 4'd2;
	localparam logic [3:0] OP_BV     = 4'd3;
	localparam logic [3:0] OP_STEPDV = 4'd4;
	localparam logic [3:0] OP_AU     = 4'd5;
	localparam logic [3:0] OP_DU2    = 4'd6;
	localparam logic [3:0] OP_STEPDU = 4'd7;
	localparam logic [3:0] OP_UUP    = 4'd8;

	typedef struct packed {
		logic       latch;
		logic       load;
		logic [3:0] op;
	} cmd_t;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic signed [VAL_W-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[VAL_W-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[VAL_W-1:0];
		end else begin
			r = x[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/izn_if.sv
// Channel interfaces: tick requests, result requests and register writes.
interface izn_tick_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] input_current;
	modport source (output valid, output input_current, input ready);
	modport sink (input valid, input input_current, output ready);
endinterface

interface izn_result_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] membrane_potential;
	logic [30:0] spike_level;
	logic        fired;
	modport source (output valid, output membrane_potential, output spike_level,
		output fired, input ready);
	modport sink (input valid, input membrane_potential, input spike_level,
		input fired, output ready);
endinterface

interface izn_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/izn_ctrl.sv
// Sequencer for the neuron step: accept, load result, eight arithmetic steps.
module izn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output izn_pkg::cmd_t  cmd
);
	import izn_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOAD   = 4'd1;
	localparam logic [3:0] ST_VV     = 4'd2;
	localparam logic [3:0] ST_CUR    = 4'd3;
	localparam logic [3:0] ST_BV     = 4'd4;
	localparam logic [3:0] ST_STEPDV = 4'd5;
	localparam logic [3:0] ST_AU     = 4'd6;
	localparam logic [3:0] ST_DU2    = 4'd7;
	localparam logic [3:0] ST_STEPDU = 4'd8;
	localparam logic [3:0] ST_UUP    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		cmd.latch = 1'b0;
		cmd.load  = 1'b0;
		cmd.op    = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					state_d  = ST_VV;
				end
			end
			ST_VV: begin
				cmd.op  = OP_VV;
				state_d = ST_CUR;
			end
			ST_CUR: begin
				cmd.op  = OP_CUR;
				state_d = ST_BV;
			end
			ST_BV: begin
				cmd.op  = OP_BV;
				state_d = ST_STEPDV;
			end
			ST_STEPDV: begin
				cmd.op  = OP_STEPDV;
				state_d = ST_AU;
			end
			ST_AU: begin
				cmd.op  = OP_AU;
				state_d = ST_DU2;
			end
			ST_DU2: begin
				cmd.op  = OP_DU2;
				state_d = ST_STEPDU;
			end
			ST_STEPDU: begin
				cmd.op  = OP_STEPDU;
				state_d = ST_UUP;
			end
			ST_UUP: begin
				cmd.op  = OP_UUP;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/izn_datapath.sv
// Datapath: registers, state, shared multiplier and saturating adders.
module izn_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  izn_pkg::cmd_t        cmd,
	input  logic signed [31:0]   cur,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic signed [31:0]   v_out,
	output logic [30:0]          level_out,
	output logic                 fired_out
);
	import izn_pkg::*;

	logic signed [VAL_W-1:0]  rate_q, sens_q, cpot_q, jump_q, thr_q, weight_q;
	logic [UVAL_W-1:0]        step_q, amp_q;
	logic signed [VAL_W-1:0]  pot_q, rec_q;
	logic signed [VAL_W-1:0]  cur_q;
	logic signed [VAL_W-1:0]  dv_q, du_q;
	logic [SQ_W-1:0]          sq_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [VAL_W:0]    opa, opb;
	logic signed [49:0]       ps;
	logic signed [SUM_W-1:0]  ps_x, pot_x, rec_x, jump_x;
	logic [59:0]              sqm;
	logic                     spike;

	assign ps     = prod_q[65:16];
	assign ps_x   = $signed({{2{ps[49]}}, ps});
	assign pot_x  = $signed({{20{pot_q[31]}}, pot_q});
	assign rec_x  = $signed({{20{rec_q[31]}}, rec_q});
	assign jump_x = $signed({{20{jump_q[31]}}, jump_q});
	assign sqm    = prod_q[63:16] * COEF_SQUARE;
	assign spike  = (pot_q >= thr_q);

	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.op)
			OP_VV: begin
				opa = {pot_q[31], pot_q};
				opb = {pot_q[31], pot_q};
			end
			OP_CUR: begin
				opa = {cur_q[31], cur_q};
				opb = {weight_q[31], weight_q};
			end
			OP_BV: begin
				opa = {sens_q[31], sens_q};
				opb = {pot_q[31], pot_q};
			end
			OP_STEPDV: begin
				opa = $signed({2'b00, step_q});
				opb = {dv_q[31], dv_q};
			end
			OP_AU: begin
				opa = {rate_q[31], rate_q};
				opb = {du_q[31], du_q};
			end
			OP_STEPDU: begin
				opa = $signed({2'b00, step_q});
				opb = {du_q[31], du_q};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		if (cmd.latch) begin
			cur_q <= cur;
		end
		if (cmd.load) begin
			v_out     <= spike ? cpot_q : pot_q;
			level_out <= spike ? amp_q : '0;
			fired_out <= spike;
		end
		case (cmd.op)
			OP_CUR: begin
				sq_q  <= sqm[59:16];
				acc_q <= (pot_x <<< 2) + pot_x + CONST_BIAS - rec_x;
			end
			OP_BV: begin
				dv_q <= sat32($signed({8'b0, sq_q}) + acc_q + ps_x);
			end
			OP_STEPDV: begin
				du_q <= sat32(ps_x - rec_x);
			end
			OP_DU2: begin
				du_q <= sat32(ps_x);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= RATE_RESET;
			sens_q   <= SENS_RESET;
			cpot_q   <= RESET_POT_RESET;
			jump_q   <= JUMP_RESET;
			thr_q    <= THRESH_RESET;
			weight_q <= WEIGHT_RESET;
			step_q   <= STEP_RESET;
			amp_q    <= AMP_RESET;
			pot_q    <= POTENTIAL_RESET;
			rec_q    <= RECOVERY_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RECOVERY_RATE:        rate_q   <= cfg_data;
					REG_RECOVERY_SENSITIVITY: sens_q   <= cfg_data;
					REG_RESET_POTENTIAL:      cpot_q   <= cfg_data;
					REG_RECOVERY_JUMP:        jump_q   <= cfg_data;
					REG_FIRE_THRESHOLD:       thr_q    <= cfg_data;
					REG_INPUT_WEIGHT:         weight_q <= cfg_data;
					REG_STEP_MS:              step_q   <= cfg_data[30:0];
					REG_SPIKE_AMPLITUDE:      amp_q    <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
			if (cmd.load && spike) begin
				pot_q <= cpot_q;
				rec_q <= sat32(rec_x + jump_x);
			end
			case (cmd.op)
				OP_AU: begin
					pot_q <= sat32(pot_x + ps_x);
				end
				OP_UUP: begin
					rec_q <= sat32(rec_x + ps_x);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hdl/izhikevich_neuron_step_top.sv
// Top level of the Izhikevich neuron step block.
// Usage:
//   tick   : one request per time tick, carrying input_current (Q16.16).
//   result : one request per tick with membrane_potential, spike_level, fired.
//   cfg    : register writes (index, data); always ready, write only when idle.
// Timing: a tick is taken when tick.ready is high; its result is loaded into
//   the output register in the load step that follows, once that register is
//   free, and result.valid rises with it. The Euler update then runs on one
//   shared 33x33 multiplier, and a new tick is taken only after it finishes.
// Stall: while an earlier result still waits, the block takes the next tick
//   and holds in its load step until the output register frees up.
// Reset: arst_n clears the sequencer, the result valid, the state
//   (potential -65.0, recovery -13.0) and the configuration registers to their defaults.
module izhikevich_neuron_step_top (
	input  logic         clk,
	input  logic         arst_n,
	izn_tick_if.sink     tick,
	izn_result_if.source result,
	izn_cfg_if.sink      cfg
);
	import izn_pkg::*;

	cmd_t cmd;
	logic cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	izn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	izn_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cur       (tick.input_current),
		.cfg_we    (cfg_we),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.v_out     (result.membrane_potential),
		.level_out (result.spike_level),
		.fired_out (result.fired)
	);

	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> !tick.ready)
		else $error("tick accepted while a step is in progress");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> result.valid)
		else $error("result not presented after load");

	a_quiet_level: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.fired) |-> (result.spike_level == '0))
		else $error("nonzero spike level without a spike");

endmodule
